[hw/rtl/dll_pkg.sv]
package dll_pkg;

  localparam int NodeCountDef  = 256;
  localparam int ValueWidthDef = 32;
  localparam int DataW         = 32;
  localparam int CountW        = 9;

  typedef enum logic [4:0] {
    CMD_CLEAR      = 5'd0,
    CMD_INS_HEAD   = 5'd1,
    CMD_INS_TAIL   = 5'd2,
    CMD_CUR_HEAD   = 5'd3,
    CMD_CUR_TAIL   = 5'd4,
    CMD_RD_HEAD    = 5'd5,
    CMD_RD_TAIL    = 5'd6,
    CMD_DEL_HEAD   = 5'd7,
    CMD_DEL_TAIL   = 5'd8,
    CMD_DEL_AFTER  = 5'd9,
    CMD_DEL_BEFORE = 5'd10,
    CMD_INS_AFTER  = 5'd11,
    CMD_INS_BEFORE = 5'd12,
    CMD_RD_CUR     = 5'd13,
    CMD_WR_CUR     = 5'd14,
    CMD_BACK       = 5'd15,
    CMD_FWD        = 5'd16
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [4:0]        command;
    logic signed [31:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic               cursor_active;
    logic               list_empty;
    logic [8:0]         element_count;
  } out_item_t;

endpackage

[hw/rtl/doubly_linked_list_with_cursor_top.sv]
// Doubly linked list with cursor over a node pool in three synchronous RAMs
// (next links, prev links, values), each with one read and one write port.
// Each transaction steps through link reads, reads that follow a link, first writes
// and second writes; out_valid then rises and busy drops in that same cycle, so a
// new transaction is taken only once the last one is done. The receiver cannot stall results.
// Reset (synchronous, rst_n low) empties the list and the free list; RAMs keep data.
module doubly_linked_list_with_cursor_top
  import dll_pkg::*;
#(
  parameter int NODE_COUNT  = NodeCountDef,
  parameter int VALUE_WIDTH = ValueWidthDef
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);
  localparam int AW = $clog2(NODE_COUNT);
  localparam int MW = AW + 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD1  = 5'b00010,
    S_RD2  = 5'b00100,
    S_WR1  = 5'b01000,
    S_WR2  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [4:0]             cmd_r;
  logic [VALUE_WIDTH-1:0] wv_r;

  logic [AW-1:0] head_r, tail_r, cur_r, free_r;
  logic          cur_v_r, free_v_r;
  logic [MW-1:0] count_r, fresh_r;

  // Link and value data captured from the two read steps
  logic [AW-1:0]          nx1_r, pv1_r, nx2_r, pv2_r;
  logic [VALUE_WIDTH-1:0] vl1_r;
  logic [AW-1:0]          nx2, pv2;

  // RAM ports
  logic                   nx_we, pv_we, vl_we;
  logic [AW-1:0]          nx_wa, pv_wa, vl_wa, nx_ra, pv_ra, vl_ra;
  logic [AW-1:0]          nx_wd, pv_wd, nx_rd, pv_rd;
  logic [VALUE_WIDTH-1:0] vl_wd, vl_rd;

  dll_ram #(.Width(AW), .Depth(NODE_COUNT)) u_next (
    .clk, .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd));
  dll_ram #(.Width(AW), .Depth(NODE_COUNT)) u_prev (
    .clk, .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd));
  dll_ram #(.Width(VALUE_WIDTH), .Depth(NODE_COUNT)) u_val (
    .clk, .we(vl_we), .waddr(vl_wa), .wdata(vl_wd), .raddr(vl_ra), .rdata(vl_rd));

  logic accept;
  logic done;
  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign done   = (state_r == S_WR2);

  // Hold busy across the whole read-modify-write, so no two transactions ever
  // touch the RAMs at once and no forwarding is needed.
  always_comb begin
    unique case (state_r)
      S_IDLE:  state_nxt = accept ? S_RD1 : S_IDLE;
      S_RD1:   state_nxt = S_RD2;
      S_RD2:   state_nxt = S_WR1;
      S_WR1:   state_nxt = S_WR2;
      S_WR2:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Read addresses. First step: free-list pop, head/tail/cursor links and the
  // value to report. Second step: follow the link just read (the node behind
  // the victim of a delete after/before) or read the cursor's own link for
  // the insert after/before, whose next port was busy with the free pop.
  always_comb begin
    nx_ra = cur_r;
    pv_ra = cur_r;
    vl_ra = cur_r;
    if (state_r == S_RD1) begin
      case (cmd_r) inside
        CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AFTER, CMD_INS_BEFORE: nx_ra = free_r;
        CMD_DEL_HEAD: nx_ra = head_r;
        CMD_DEL_TAIL: pv_ra = tail_r;
        CMD_RD_HEAD:  vl_ra = head_r;
        CMD_RD_TAIL:  vl_ra = tail_r;
        default: ;
      endcase
    end else if (state_r == S_RD2) begin
      case (cmd_r) inside
        CMD_DEL_AFTER:  nx_ra = nx_rd;
        CMD_DEL_BEFORE: pv_ra = pv_rd;
        default: ;
      endcase
    end
  end

  // Second-step data sits on the RAM outputs during the first write step
  assign nx2 = (state_r == S_WR1) ? nx_rd : nx2_r;
  assign pv2 = (state_r == S_WR1) ? pv_rd : pv2_r;

  // Allocation: free list first, then the never-used nodes from fresh_r up
  logic          can_alloc;
  logic [AW-1:0] new_n;
  logic [MW-1:0] fresh_grow;
  assign can_alloc  = free_v_r || (fresh_r < MW'(NODE_COUNT));
  assign new_n      = free_v_r ? free_r : fresh_r[AW-1:0];
  assign fresh_grow = free_v_r ? fresh_r : fresh_r + 1'b1;

  // Write plan: set 1 goes out in S_WR1, set 2 in S_WR2
  logic          n1_we, n2_we, p1_we, p2_we, v_we;
  logic [AW-1:0] n1_wa, n1_wd, n2_wa, n2_wd, p1_wa, p1_wd, p2_wa, p2_wd, v_wa;
  out_item_t     res;
  logic [AW-1:0] head_nxt, tail_nxt, cur_nxt, free_nxt;
  logic          cur_v_nxt, free_v_nxt;
  logic [MW-1:0] count_nxt, fresh_nxt;

  always_comb begin
    head_nxt = head_r; tail_nxt = tail_r; cur_nxt = cur_r; free_nxt = free_r;
    cur_v_nxt = cur_v_r; free_v_nxt = free_v_r;
    count_nxt = count_r; fresh_nxt = fresh_r;
    n1_we = 1'b0; n1_wa = '0; n1_wd = '0;
    n2_we = 1'b0; n2_wa = '0; n2_wd = '0;
    p1_we = 1'b0; p1_wa = '0; p1_wd = '0;
    p2_we = 1'b0; p2_wa = '0; p2_wd = '0;
    v_we = 1'b0; v_wa = cur_r;
    res = '0;

    case (cmd_r) inside
      CMD_CLEAR: begin
        head_nxt = '0; tail_nxt = '0; cur_nxt = '0; cur_v_nxt = 1'b0;
        count_nxt = '0; fresh_nxt = '0; free_nxt = '0; free_v_nxt = 1'b0;
      end
      CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AFTER, CMD_INS_BEFORE: begin
        if (!cur_v_r && (cmd_r == CMD_INS_AFTER || cmd_r == CMD_INS_BEFORE)) begin
          // no cursor to insert at: drop the command
        end else if (!can_alloc) begin
          res.status = ST_FULL;
        end else begin
          count_nxt  = count_r + 1'b1;
          fresh_nxt  = fresh_grow;
          free_nxt   = free_v_r ? nx1_r : free_r;
          free_v_nxt = fresh_grow > (count_r + 1'b1);
          v_we = 1'b1; v_wa = new_n;
          case (cmd_r) inside
            CMD_INS_HEAD: begin
              n1_we = 1'b1; n1_wa = new_n; n1_wd = head_r;
              p1_we = 1'b1; p1_wa = new_n; p1_wd = '0;
              p2_we = (count_r != '0); p2_wa = head_r; p2_wd = new_n;
              head_nxt = new_n;
              if (count_r == '0) tail_nxt = new_n;
            end
            CMD_INS_TAIL: begin
              n1_we = 1'b1; n1_wa = new_n; n1_wd = '0;
              p1_we = 1'b1; p1_wa = new_n; p1_wd = tail_r;
              n2_we = (count_r != '0); n2_wa = tail_r; n2_wd = new_n;
              tail_nxt = new_n;
              if (count_r == '0) head_nxt = new_n;
            end
            CMD_INS_AFTER: begin
              // nx2 is the cursor's old successor
              n1_we = 1'b1; n1_wa = new_n; n1_wd = nx2;
              p1_we = 1'b1; p1_wa = new_n; p1_wd = cur_r;
              n2_we = 1'b1; n2_wa = cur_r; n2_wd = new_n;
              p2_we = (cur_r != tail_r); p2_wa = nx2; p2_wd = new_n;
              if (cur_r == tail_r) tail_nxt = new_n;
            end
            default: begin
              // pv2 is the cursor's old predecessor
              n1_we = 1'b1; n1_wa = new_n; n1_wd = cur_r;
              p1_we = 1'b1; p1_wa = new_n; p1_wd = pv2;
              p2_we = 1'b1; p2_wa = cur_r; p2_wd = new_n;
              n2_we = (cur_r != head_r); n2_wa = pv2; n2_wd = new_n;
              if (cur_r == head_r) head_nxt = new_n;
            end
          endcase
        end
      end
      CMD_CUR_HEAD, CMD_CUR_TAIL: begin
        cur_v_nxt = (count_r != '0);
        if (count_r != '0) cur_nxt = (cmd_r == CMD_CUR_HEAD) ? head_r : tail_r;
      end
      CMD_RD_HEAD, CMD_RD_TAIL: begin
        if (count_r == '0) res.status = ST_EMPTY;
        else res.read_value = DataW'(signed'(vl1_r));
      end
      CMD_RD_CUR: begin
        if (!cur_v_r) res.status = ST_EMPTY;
        else res.read_value = DataW'(signed'(vl1_r));
      end
      CMD_WR_CUR: begin
        v_we = cur_v_r; v_wa = cur_r;
      end
      CMD_DEL_HEAD: begin
        if (count_r != '0) begin
          if (cur_v_r && cur_r == head_r) cur_v_nxt = 1'b0;
          if (count_r == MW'(1)) begin
            head_nxt = '0; tail_nxt = '0;
          end else begin
            head_nxt = nx1_r;
            p1_we = 1'b1; p1_wa = nx1_r; p1_wd = '0;
          end
          // push the old head onto the free list
          n1_we = 1'b1; n1_wa = head_r; n1_wd = free_r;
          free_nxt = head_r; free_v_nxt = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      CMD_DEL_TAIL: begin
        if (count_r != '0) begin
          if (cur_v_r && cur_r == tail_r) cur_v_nxt = 1'b0;
          if (count_r == MW'(1)) begin
            head_nxt = '0; tail_nxt = '0;
          end else begin
            tail_nxt = pv1_r;
            n1_we = 1'b1; n1_wa = pv1_r; n1_wd = '0;
          end
          n2_we = 1'b1; n2_wa = tail_r; n2_wd = free_r;
          free_nxt = tail_r; free_v_nxt = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      CMD_DEL_AFTER: begin
        // victim nx1_r, the node behind it nx2
        if (cur_v_r && cur_r != tail_r) begin
          n1_we = 1'b1; n1_wa = cur_r; n1_wd = nx2;
          if (nx1_r == tail_r) tail_nxt = cur_r;
          else begin
            p1_we = 1'b1; p1_wa = nx2; p1_wd = cur_r;
          end
          n2_we = 1'b1; n2_wa = nx1_r; n2_wd = free_r;
          free_nxt = nx1_r; free_v_nxt = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      CMD_DEL_BEFORE: begin
        // victim pv1_r, the node ahead of it pv2
        if (cur_v_r && cur_r != head_r) begin
          p1_we = 1'b1; p1_wa = cur_r; p1_wd = pv2;
          if (pv1_r == head_r) head_nxt = cur_r;
          else begin
            n1_we = 1'b1; n1_wa = pv2; n1_wd = cur_r;
          end
          n2_we = 1'b1; n2_wa = pv1_r; n2_wd = free_r;
          free_nxt = pv1_r; free_v_nxt = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      CMD_BACK: begin
        if (cur_v_r) begin
          if (cur_r == head_r) cur_v_nxt = 1'b0;
          else cur_nxt = pv1_r;
        end
      end
      CMD_FWD: begin
        if (cur_v_r) begin
          if (cur_r == tail_r) cur_v_nxt = 1'b0;
          else cur_nxt = nx1_r;
        end
      end
      default: ;
    endcase

    res.cursor_active = cur_v_nxt;
    res.list_empty    = (count_nxt == '0);
    res.element_count = CountW'(count_nxt);
  end

  // Steer the write plan onto the single write port of each RAM
  assign vl_we = v_we && (state_r == S_WR1);
  assign vl_wa = v_wa;
  assign vl_wd = wv_r;

  always_comb begin
    nx_we = 1'b0; nx_wa = n1_wa; nx_wd = n1_wd;
    pv_we = 1'b0; pv_wa = p1_wa; pv_wd = p1_wd;
    if (state_r == S_WR1) begin
      nx_we = n1_we;
      pv_we = p1_we;
    end else if (state_r == S_WR2) begin
      nx_we = n2_we; nx_wa = n2_wa; nx_wd = n2_wd;
      pv_we = p2_we; pv_wa = p2_wa; pv_wd = p2_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r <= '0; tail_r <= '0; cur_r <= '0; free_r <= '0;
      cur_v_r <= 1'b0; free_v_r <= 1'b0; count_r <= '0; fresh_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= done;
      // advance the list pointers once, at the end of the transaction
      if (done) begin
        head_r <= head_nxt; tail_r <= tail_nxt; cur_r <= cur_nxt; free_r <= free_nxt;
        cur_v_r <= cur_v_nxt; free_v_r <= free_v_nxt;
        count_r <= count_nxt; fresh_r <= fresh_nxt;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_item.command;
      wv_r  <= VALUE_WIDTH'(in_item.write_value);
    end
    if (state_r == S_RD2) begin
      nx1_r <= nx_rd; pv1_r <= pv_rd; vl1_r <= vl_rd;
    end
    if (state_r == S_WR1) begin
      nx2_r <= nx_rd; pv2_r <= pv_rd;
    end
    if (done) out_item <= res;
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  a_busy_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without work");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= fresh_r) else $error("count above fresh mark");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> !cur_v_r) else $error("cursor on empty list");

endmodule

[hw/rtl/dll_ram.sv]
module dll_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
